/* rtl/signed_int_to_decimal_ascii_assert.svh */
// Assertion macros for the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sida_pkg.sv */
package sida_pkg;

  localparam int DATA_WIDTH = 32;
  // Decimal digits of 2^(DATA_WIDTH-1); 3/10 bounds log10(2) from below.
  localparam int NUM_DIGITS = (DATA_WIDTH * 3) / 10 + 1;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(DATA_WIDTH);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } dab_state_t;

  // Converted value handed from the converter to the character emitter.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } sida_hand_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CHAR_ZERO + {4'b0000, d};
  endfunction

endpackage

/* rtl/sida_in_if.sv */
interface sida_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sida_pkg::DATA_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/sida_out_if.sv */
interface sida_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

/* rtl/sida_dabble.sv */
module sida_dabble (
  input  logic                 clk,
  input  logic                 rst,
  sida_in_if.sink              value_ch,
  output logic                 hand_valid,
  output sida_pkg::sida_hand_t hand,
  input  logic                 hand_ready
);
  import sida_pkg::*;

  dab_state_t             state, state_next;
  logic [DATA_WIDTH-1:0]  mag;
  logic [BCD_W-1:0]       bcd, bcd_adj;
  logic                   neg;
  logic [BIT_CNT_W-1:0]   bit_cnt;

  // add-3 on every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (value_ch.valid) state_next = ST_SHIFT;
      ST_SHIFT: if (bit_cnt == '0) state_next = ST_DONE;
      ST_DONE:  if (hand_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    value_ch.ready = 1'b0;
    hand_valid     = 1'b0;
    unique case (state)
      ST_IDLE:  value_ch.ready = 1'b1;
      ST_SHIFT: ;
      ST_DONE:  hand_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      neg     <= value_ch.value[DATA_WIDTH-1];
      mag     <= value_ch.value[DATA_WIDTH-1] ? DATA_WIDTH'(~value_ch.value + 1'b1)
                                              : DATA_WIDTH'(value_ch.value);
      bcd     <= '0;
      bit_cnt <= BIT_CNT_W'(DATA_WIDTH - 1);
    end else if (state == ST_SHIFT) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[DATA_WIDTH-1]};
      mag     <= {mag[DATA_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  assign hand.neg = neg;
  assign hand.bcd = bcd;

endmodule

/* rtl/sida_emit.sv */
module sida_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hand_valid,
  input  sida_pkg::sida_hand_t hand,
  output logic                 hand_ready,
  sida_out_if.source           text_ch
);
  import sida_pkg::*;

  logic                 busy;
  logic                 neg_pend;
  logic                 started;
  logic [DIG_CNT_W-1:0] cnt;
  logic [BCD_W-1:0]     dig;
  logic [3:0]           top;
  logic                 adv;
  logic                 produce;
  logic                 out_valid;
  logic [7:0]           out_char;
  logic                 out_last;

  assign top        = dig[BCD_W-1 -: 4];
  assign hand_ready = !busy;
  // output register free or being emptied this cycle
  assign adv        = !out_valid || text_ch.ready;
  // leading zeros are dropped, but the units digit always goes out
  assign produce    = busy && (neg_pend || started || top != 4'd0 || cnt == DIG_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!busy && hand_valid) begin
        busy <= 1'b1;
      end else if (busy && adv && !neg_pend && cnt == DIG_CNT_W'(1)) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && hand_valid) begin
      neg_pend <= hand.neg;
      started  <= 1'b0;
      cnt      <= DIG_CNT_W'(NUM_DIGITS);
      dig      <= hand.bcd;
    end else if (busy && adv) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
        out_char <= CHAR_MINUS;
        out_last <= 1'b0;
      end else begin
        dig <= {dig[BCD_W-5:0], 4'd0};
        cnt <= cnt - 1'b1;
        if (produce) begin
          started  <= 1'b1;
          out_char <= digit_char(top);
          out_last <= (cnt == DIG_CNT_W'(1));
        end
      end
    end
  end

  assign text_ch.valid     = out_valid;
  assign text_ch.text_char = out_char;
  assign text_ch.last      = out_last;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Channel    Dir  Payload                 Transfer
// value_ch   in   value (32b signed)      valid && ready
// text_ch    out  text_char (8b), last    valid && ready
//
// A value is converted in order: the accept cycle loads the magnitude,
// shift-and-add-3 steps follow (one magnitude bit each), then the done
// state hands the digits over. The emitter steps through every digit slot
// (10) plus one step for a sign; the next value is taken while the emitter
// still works. Reset (rst, synchronous) clears both control paths. A stalled
// text_ch holds the emitter; the converter waits in done.
module signed_int_to_decimal_ascii (
  input  logic       clk,
  input  logic       rst,
  sida_in_if.sink    value_ch,
  sida_out_if.source text_ch
);
  import sida_pkg::*;
  `include "signed_int_to_decimal_ascii_assert.svh"

  logic       hand_valid;
  logic       hand_ready;
  sida_hand_t hand;

  // Binary to BCD, MSB of the magnitude first.
  sida_dabble u_dabble (
    .clk        (clk),
    .rst        (rst),
    .value_ch   (value_ch),
    .hand_valid (hand_valid),
    .hand       (hand),
    .hand_ready (hand_ready)
  );

  // Sign, leading-zero skip and character output register.
  sida_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .hand_valid (hand_valid),
    .hand       (hand),
    .hand_ready (hand_ready),
    .text_ch    (text_ch)
  );

  // Only the sign or a decimal digit ever goes out.
  `SIDA_ASSERT_NOW(a_char_range, clk, rst, text_ch.valid,
    text_ch.text_char == CHAR_MINUS ||
    (text_ch.text_char >= CHAR_ZERO && text_ch.text_char <= CHAR_NINE),
    "bad character")
  // A sign is always followed by at least one digit.
  `SIDA_ASSERT_NOW(a_minus_not_last, clk, rst,
    text_ch.valid && text_ch.text_char == CHAR_MINUS, !text_ch.last,
    "sign marked last")
  // Converter is busy for the cycle after it takes a value.
  `SIDA_ASSERT_NEXT(a_busy_after_take, clk, rst,
    value_ch.valid && value_ch.ready, !value_ch.ready,
    "converter took two values back to back")

endmodule
